// ----- design/mpre_pkg.sv -----
`timescale 1ns / 1ps
package mpre_pkg;
   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int SYM_FIFO_DEPTH = 2;
   localparam int WORD_FIFO_DEPTH = 4;
   localparam int NUM_MODELS = 3;
   localparam int NUM_SYMBOLS = 256;
   localparam int MODEL_DEPTH = NUM_MODELS * NUM_SYMBOLS;
   localparam int MODEL_AW = $clog2(MODEL_DEPTH);
   localparam int ROW_ENTRY_WIDTH = 27;

   localparam logic [47:0] CODER_MASK = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] RENORM_LIMIT = 48'h1_0000;
   localparam logic [16:0] PROB_ONE = 17'h1_0000;
   localparam logic [15:0] PROB_SCALE = 16'd65280;
   localparam logic [15:0] TOTAL_RESET = 16'd256;

   localparam logic [1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;

   typedef struct packed {
      logic [2:0][7:0] sym;
      logic            row_end;
      logic            image_end;
   } mpre_sym_type;

   typedef struct packed {
      logic [15:0] code_word;
      logic        last_of_run;
      logic        end_of_stream;
   } mpre_word_type;

   typedef enum logic {
      F_IDLE,
      F_CALC
   } mpre_front_state_type;

   typedef enum logic [4:0] {
      B_CLEAR,
      B_IDLE,
      B_RENORM,
      B_RD1,
      B_RD2,
      B_MUL0,
      B_MUL1,
      B_MUL2,
      B_MUL3,
      B_MUL4,
      B_MUL5,
      B_FLUSH,
      B_FIN,
      B_RB_RD,
      B_RB_MUL,
      B_RB_DIV,
      B_RB_WR
   } mpre_back_state_type;
endpackage

// ----- design/med_predicted_range_image_encoder_unit.sv -----
`timescale 1ns / 1ps
// lossless rgb encoder: median edge prediction and an adaptive 48-bit range coder
// pixels enter in raster order on req_*: push is taken when full is low
// coded 16-bit words leave on rsp_*: the oldest word is shown while empty is low
// and pop takes it; last_of_run marks the last word of a pixel, end_of_stream
// the third flush word after the last pixel of the image
// csr_write with csr_index 0 sets the image width, index 1 the height; write
// only while the block is idle
// a pixel passes a row memory read, then prediction, in the front; in the coder
// its 3 symbols are coded in turn on one shared 24x17 multiplier
// at a row end the coder rebuilds the three cumulative tables: 768 entries, each
// worked out through a 16-step divider
// after reset, and after the flush of each image, the 768-entry model tables
// are cleared with full held high
// a stalled receiver fills the 4-word output queue and then holds the coder;
// the 2-entry symbol queue then fills and full goes high
module med_predicted_range_image_encoder_unit import mpre_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_code_word,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_stream,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic pixel_ready, pixel_valid, clearing;
   logic sym_push, sym_full, sym_pop, sym_empty;
   mpre_sym_type sym_in_data, sym_out_data;
   logic word_push, word_full;
   mpre_word_type word_in_data, word_out_data;

   assign req_full = !pixel_ready || clearing;
   assign pixel_valid = req_push && !req_full;

   mpre_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .pixel_valid(pixel_valid),
      .pixel_ready(pixel_ready),
      .red(req_red),
      .green(req_green),
      .blue(req_blue),
      .sym_push(sym_push),
      .sym_data(sym_in_data),
      .sym_full(sym_full)
   );

   mpre_fifo #(.WIDTH($bits(mpre_sym_type)), .DEPTH(SYM_FIFO_DEPTH)) u_sym_fifo (
      .clock(clock),
      .reset(reset),
      .push(sym_push),
      .push_data(sym_in_data),
      .full(sym_full),
      .pop(sym_pop),
      .pop_data(sym_out_data),
      .empty(sym_empty)
   );

   mpre_back u_back (
      .clock(clock),
      .reset(reset),
      .sym_empty(sym_empty),
      .sym_pop(sym_pop),
      .sym_data(sym_out_data),
      .word_push(word_push),
      .word_data(word_in_data),
      .word_full(word_full),
      .clearing(clearing)
   );

   mpre_fifo #(.WIDTH($bits(mpre_word_type)), .DEPTH(WORD_FIFO_DEPTH)) u_word_fifo (
      .clock(clock),
      .reset(reset),
      .push(word_push),
      .push_data(word_in_data),
      .full(word_full),
      .pop(rsp_pop),
      .pop_data(word_out_data),
      .empty(rsp_empty)
   );

   assign rsp_code_word = word_out_data.code_word;
   assign rsp_last_of_run = word_out_data.last_of_run;
   assign rsp_end_of_stream = word_out_data.end_of_stream;
endmodule

// ----- design/mpre_ram.sv -----
`timescale 1ns / 1ps
module mpre_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;
endmodule

// ----- design/mpre_fifo.sv -----
`timescale 1ns / 1ps
module mpre_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : AW'(rd_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

// ----- design/mpre_front.sv -----
`timescale 1ns / 1ps
module mpre_front import mpre_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data,
   input  logic         pixel_valid,
   output logic         pixel_ready,
   input  logic [7:0]   red,
   input  logic [7:0]   green,
   input  logic [7:0]   blue,
   output logic         sym_push,
   output mpre_sym_type sym_data,
   input  logic         sym_full
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int FW = $clog2(MAX_WIDTH + 1);
   localparam int EW = (FW > 13) ? FW : 13;
   localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);

   mpre_front_state_type state_ff, state_in;
   logic [12:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [CW-1:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [2:0][8:0] west_ff, west_in, nw_ff, nw_in;

   logic [ROW_ENTRY_WIDTH-1:0] row_rdata;
   logic row_write;
   logic [2:0][8:0] nb, wv, nwv, cur;
   logic [EW-1:0] effw, col_next;
   logic [15:0] effh;
   logic row_end, image_end;
   logic [8:0] g0, p0, m1, m2;
   logic signed [9:0] p1s, p2s;
   logic [7:0] p1c, p2c;
   logic [FW-1:0] col_fill;

   function automatic logic [8:0] med_pred(input logic signed [8:0] n,
                                           input logic signed [8:0] w,
                                           input logic signed [8:0] nw);
      logic signed [8:0] lo;
      logic signed [8:0] hi;
      logic signed [10:0] p;
      logic [8:0] r;
      lo = (n < w) ? n : w;
      hi = (n < w) ? w : n;
      p = 11'(n) + 11'(w) - 11'(nw);
      if (p < 11'(lo)) begin
         r = lo;
      end else if (p > 11'(hi)) begin
         r = hi;
      end else begin
         r = p[8:0];
      end
      return r;
   endfunction

   function automatic logic [7:0] clamp8(input logic signed [9:0] v);
      logic [7:0] r;
      if (v < -10'sd128) begin
         r = 8'h80;
      end else if (v > 10'sd127) begin
         r = 8'h7F;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   // sign folding: 0,-1,1,-2 -> 0,1,2,3
   function automatic logic [7:0] fold(input logic [7:0] d);
      return {d[6:0], 1'b0} ^ {8{d[7]}};
   endfunction

   mpre_ram #(
      .WIDTH(ROW_ENTRY_WIDTH),
      .DEPTH(MAX_WIDTH)
   ) u_row_ram (
      .clock(clock),
      .write_enable(row_write),
      .write_address(col_ff),
      .write_data(cur),
      .read_address(col_ff),
      .read_data(row_rdata)
   );

   assign pixel_ready = (state_ff == F_IDLE);

   always_comb begin
      effw = (width_ff == '0) ? EW'(1) : ((EW'(width_ff) > MAX_W) ? MAX_W : EW'(width_ff));
      effh = (height_ff == '0) ? 16'd1 : height_ff;
      col_next = EW'(col_ff) + EW'(1);
      row_end = (col_next >= effw);
      image_end = row_end && ((17'(row_ff) + 17'd1) >= 17'(effh));
      col_fill = FW'(col_ff) + FW'(1);

      // entries past the fill mark were not written in this image
      nb = (FW'(col_ff) < fill_ff) ? row_rdata : '0;
      wv = (col_ff == '0) ? '0 : west_ff;
      nwv = (col_ff == '0) ? '0 : nw_ff;

      g0 = 9'({1'b0, green_ff}) - 9'd128;
      cur[0] = g0;
      cur[1] = {1'b0, blue_ff} - {1'b0, green_ff};
      cur[2] = {1'b0, red_ff} - {1'b0, green_ff};

      p0 = med_pred(nb[0], wv[0], nwv[0]);
      m1 = med_pred(nb[1], wv[1], nwv[1]);
      m2 = med_pred(nb[2], wv[2], nwv[2]);
      p1s = 10'($signed(m1)) + 10'($signed(g0));
      p2s = 10'($signed(m2)) + 10'($signed(g0));
      p1c = clamp8(p1s);
      p2c = clamp8(p2s);

      sym_data.sym[0] = fold(g0[7:0] - p0[7:0]);
      sym_data.sym[1] = fold((blue_ff ^ 8'h80) - p1c);
      sym_data.sym[2] = fold((red_ff ^ 8'h80) - p2c);
      sym_data.row_end = row_end;
      sym_data.image_end = image_end;
   end

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: width_in = csr_data[12:0];
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end

      state_in = state_ff;
      red_in = red_ff;
      green_in = green_ff;
      blue_in = blue_ff;
      col_in = col_ff;
      row_in = row_ff;
      fill_in = fill_ff;
      west_in = west_ff;
      nw_in = nw_ff;
      row_write = 1'b0;
      sym_push = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (pixel_valid) begin
               red_in = red;
               green_in = green;
               blue_in = blue;
               state_in = F_CALC;
            end
         end
         F_CALC: begin
            if (!sym_full) begin
               sym_push = 1'b1;
               row_write = 1'b1;
               west_in = cur;
               nw_in = nb;
               if (col_fill > fill_ff) begin
                  fill_in = col_fill;
               end
               if (row_end) begin
                  col_in = '0;
                  if (image_end) begin
                     row_in = '0;
                     fill_in = '0;
                  end else begin
                     row_in = row_ff + 16'd1;
                  end
               end else begin
                  col_in = col_next[CW-1:0];
               end
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         width_ff <= 13'd1;
         height_ff <= 16'd1;
         col_ff <= '0;
         row_ff <= '0;
         fill_ff <= '0;
         west_ff <= '0;
         nw_ff <= '0;
      end else begin
         state_ff <= state_in;
         width_ff <= width_in;
         height_ff <= height_in;
         col_ff <= col_in;
         row_ff <= row_in;
         fill_ff <= fill_in;
         west_ff <= west_in;
         nw_ff <= nw_in;
      end
      red_ff <= red_in;
      green_ff <= green_in;
      blue_ff <= blue_in;
   end
endmodule

// ----- design/mpre_back.sv -----
`timescale 1ns / 1ps
module mpre_back import mpre_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          sym_empty,
   output logic          sym_pop,
   input  mpre_sym_type  sym_data,
   output logic          word_push,
   output mpre_word_type word_data,
   input  logic          word_full,
   output logic          clearing
);
   mpre_back_state_type state_ff, state_in;
   logic [MODEL_AW-1:0] idx_ff, idx_in;
   mpre_sym_type item_ff, item_in;
   logic [1:0] m_ff, m_in, iter_ff, iter_in;
   logic [47:0] low_ff, low_in, range_ff, range_in;
   logic [15:0] cdf_ff, cdf_in;
   logic [16:0] freq_ff, freq_in;
   logic [40:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [2:0][15:0] totals_ff, totals_in;
   logic [15:0] pend_word_ff, pend_word_in;
   logic pend_valid_ff, pend_valid_in;
   logic [7:0] k_ff, k_in;
   logic [15:0] c_ff, c_in, sum_ff, sum_in, cnt_ff, cnt_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [3:0] dcnt_ff, dcnt_in;

   logic cnt_we, cum_we;
   logic [MODEL_AW-1:0] cnt_waddr, cnt_raddr, cum_waddr, cum_raddr;
   logic [15:0] cnt_wdata, cnt_rdata, cum_wdata, cum_rdata;
   logic [23:0] mul_a;
   logic [16:0] mul_b;

   logic [7:0] sym_cur;
   logic [MODEL_AW-1:0] model_addr, model_addr_next, rb_addr;
   logic [47:0] low_sh, range_sh, range_rn;
   logic need_renorm, word_ok;
   logic [15:0] flush_word, divisor, half;
   logic [16:0] top, dtrial;
   logic [31:0] dvd;

   mpre_ram #(.WIDTH(16), .DEPTH(MODEL_DEPTH)) u_count_ram (
      .clock(clock),
      .write_enable(cnt_we),
      .write_address(cnt_waddr),
      .write_data(cnt_wdata),
      .read_address(cnt_raddr),
      .read_data(cnt_rdata)
   );

   mpre_ram #(.WIDTH(16), .DEPTH(MODEL_DEPTH)) u_cum_ram (
      .clock(clock),
      .write_enable(cum_we),
      .write_address(cum_waddr),
      .write_data(cum_wdata),
      .read_address(cum_raddr),
      .read_data(cum_rdata)
   );

   assign clearing = (state_ff == B_CLEAR);
   assign prod_in = 41'(mul_a) * 41'(mul_b);

   always_comb begin
      sym_cur = item_ff.sym[m_ff];
      model_addr = MODEL_AW'({m_ff, sym_cur});
      model_addr_next = MODEL_AW'({m_ff, 8'(sym_cur + 8'd1)});
      rb_addr = MODEL_AW'({m_ff, k_ff});
      low_sh = {low_ff[31:0], 16'h0000};
      range_sh = {range_ff[31:0], 16'hFFFF};
      // range may not pass the distance from low to the top of the interval
      range_rn = (range_sh > ~low_sh) ? ~low_sh : range_sh;
      need_renorm = (range_ff < RENORM_LIMIT) && (iter_ff != 2'd3);
      word_ok = !pend_valid_ff || !word_full;
      case (iter_ff)
         2'd0: flush_word = low_ff[47:32];
         2'd1: flush_word = low_ff[31:16];
         default: flush_word = low_ff[15:0];
      endcase
      top = (sym_cur == 8'hFF) ? PROB_ONE : {1'b0, cum_rdata};
      divisor = (totals_ff[m_ff] == '0) ? 16'd1 : totals_ff[m_ff];
      half = 16'((17'(cnt_rdata) + 17'd1) >> 1);
      dvd = 32'(c_ff) * 32'(PROB_SCALE);
      dtrial = {rem_ff[15:0], quo_ff[15]};
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      item_in = item_ff;
      m_in = m_ff;
      iter_in = iter_ff;
      low_in = low_ff;
      range_in = range_ff;
      cdf_in = cdf_ff;
      freq_in = freq_ff;
      acc_in = acc_ff;
      totals_in = totals_ff;
      pend_word_in = pend_word_ff;
      pend_valid_in = pend_valid_ff;
      k_in = k_ff;
      c_in = c_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dcnt_in = dcnt_ff;
      sym_pop = 1'b0;
      word_push = 1'b0;
      word_data.code_word = pend_word_ff;
      word_data.last_of_run = 1'b0;
      word_data.end_of_stream = 1'b0;
      cnt_we = 1'b0;
      cnt_waddr = model_addr;
      cnt_wdata = 16'(cnt_rdata + 16'd1);
      cnt_raddr = model_addr;
      cum_we = 1'b0;
      cum_waddr = rb_addr;
      cum_wdata = quo_ff + {8'h00, k_ff};
      cum_raddr = model_addr;
      mul_a = range_ff[23:0];
      mul_b = {1'b0, cdf_ff};

      case (state_ff)
         B_CLEAR: begin
            cnt_we = 1'b1;
            cnt_waddr = idx_ff;
            cnt_wdata = 16'd1;
            cum_we = 1'b1;
            cum_waddr = idx_ff;
            cum_wdata = {idx_ff[7:0], 8'h00};
            idx_in = MODEL_AW'(idx_ff + 1'b1);
            if (idx_ff == MODEL_AW'(MODEL_DEPTH - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!sym_empty) begin
               sym_pop = 1'b1;
               item_in = sym_data;
               m_in = 2'd0;
               iter_in = 2'd0;
               state_in = B_RENORM;
            end
         end
         B_RENORM: begin
            if (need_renorm) begin
               if (word_ok) begin
                  word_push = pend_valid_ff;
                  pend_word_in = low_ff[47:32];
                  pend_valid_in = 1'b1;
                  low_in = low_sh;
                  range_in = range_rn;
                  iter_in = iter_ff + 2'd1;
               end
            end else begin
               state_in = B_RD1;
            end
         end
         B_RD1: begin
            cdf_in = cum_rdata;
            cnt_we = 1'b1;
            cum_raddr = model_addr_next;
            state_in = B_RD2;
         end
         B_RD2: begin
            freq_in = top - {1'b0, cdf_ff};
            state_in = B_MUL0;
         end
         B_MUL0: begin
            state_in = B_MUL1;
         end
         B_MUL1: begin
            acc_in = 64'(prod_ff);
            mul_a = range_ff[47:24];
            state_in = B_MUL2;
         end
         B_MUL2: begin
            acc_in = acc_ff + {prod_ff[39:0], 24'h000000};
            mul_b = freq_ff;
            state_in = B_MUL3;
         end
         B_MUL3: begin
            low_in = low_ff + acc_ff[63:16];
            acc_in = 64'(prod_ff);
            mul_a = range_ff[47:24];
            mul_b = freq_ff;
            state_in = B_MUL4;
         end
         B_MUL4: begin
            acc_in = acc_ff + {prod_ff[39:0], 24'h000000};
            state_in = B_MUL5;
         end
         B_MUL5: begin
            range_in = acc_ff[63:16] - 48'd1;
            totals_in[m_ff] = totals_ff[m_ff] + 16'd1;
            iter_in = 2'd0;
            if (m_ff == 2'd2) begin
               state_in = item_ff.image_end ? B_FLUSH : B_FIN;
            end else begin
               m_in = m_ff + 2'd1;
               state_in = B_RENORM;
            end
         end
         B_FLUSH: begin
            if (word_ok) begin
               word_push = pend_valid_ff;
               pend_word_in = flush_word;
               pend_valid_in = 1'b1;
               iter_in = iter_ff + 2'd1;
               if (iter_ff == 2'd2) begin
                  state_in = B_FIN;
               end
            end
         end
         B_FIN: begin
            // the held word is the last one this pixel produced
            if (word_ok) begin
               word_push = pend_valid_ff;
               word_data.last_of_run = 1'b1;
               word_data.end_of_stream = item_ff.image_end;
               pend_valid_in = 1'b0;
               m_in = 2'd0;
               k_in = '0;
               c_in = '0;
               sum_in = '0;
               if (item_ff.image_end) begin
                  idx_in = '0;
                  low_in = '0;
                  range_in = CODER_MASK;
                  totals_in = {3{TOTAL_RESET}};
                  state_in = B_CLEAR;
               end else if (item_ff.row_end) begin
                  state_in = B_RB_RD;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         B_RB_RD: begin
            cnt_raddr = rb_addr;
            state_in = B_RB_MUL;
         end
         B_RB_MUL: begin
            cnt_in = cnt_rdata;
            cnt_we = 1'b1;
            cnt_waddr = rb_addr;
            cnt_wdata = half;
            sum_in = sum_ff + half;
            rem_in = {1'b0, dvd[31:16]};
            quo_in = dvd[15:0];
            dcnt_in = '0;
            state_in = B_RB_DIV;
         end
         B_RB_DIV: begin
            if (dtrial >= {1'b0, divisor}) begin
               rem_in = dtrial - {1'b0, divisor};
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = dtrial;
               quo_in = {quo_ff[14:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 4'd1;
            if (dcnt_ff == 4'd15) begin
               state_in = B_RB_WR;
            end
         end
         B_RB_WR: begin
            cum_we = 1'b1;
            c_in = c_ff + cnt_ff;
            k_in = k_ff + 8'd1;
            if (k_ff == 8'hFF) begin
               totals_in[m_ff] = sum_ff;
               c_in = '0;
               sum_in = '0;
               if (m_ff == 2'd2) begin
                  state_in = B_IDLE;
               end else begin
                  m_in = m_ff + 2'd1;
                  state_in = B_RB_RD;
               end
            end else begin
               state_in = B_RB_RD;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         idx_ff <= '0;
         m_ff <= '0;
         iter_ff <= '0;
         k_ff <= '0;
         low_ff <= '0;
         range_ff <= CODER_MASK;
         totals_ff <= {3{TOTAL_RESET}};
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         m_ff <= m_in;
         iter_ff <= iter_in;
         k_ff <= k_in;
         low_ff <= low_in;
         range_ff <= range_in;
         totals_ff <= totals_in;
         pend_valid_ff <= pend_valid_in;
      end
      item_ff <= item_in;
      cdf_ff <= cdf_in;
      freq_ff <= freq_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      pend_word_ff <= pend_word_in;
      c_ff <= c_in;
      sum_ff <= sum_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dcnt_ff <= dcnt_in;
   end
endmodule

// ----- design/mpre_checker.sv -----
`timescale 1ns / 1ps
module mpre_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic [7:0]  req_red,
   input logic [7:0]  req_green,
   input logic [7:0]  req_blue,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_code_word,
   input logic        rsp_last_of_run,
   input logic        rsp_end_of_stream,
   input logic        csr_write,
   input logic [1:0]  csr_index,
   input logic [15:0] csr_data
);
   // the closing flush word always ends the run of its pixel
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_end_of_stream) |-> rsp_last_of_run)
      else $error("end_of_stream without last_of_run");

   // model tables are cleared after reset: no words, no pixels taken
   assert property (@(posedge clock) reset |=> (rsp_empty && req_full))
      else $error("block not held after reset");

   // the front works one pixel at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("pixel taken while the front is busy");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_code_word) &&
         $stable(rsp_last_of_run) && $stable(rsp_end_of_stream)))
      else $error("waiting word changed");
endmodule

bind med_predicted_range_image_encoder_unit mpre_checker u_checker (.*);

// ----- test/tb_med_predicted_range_image_encoder_unit.sv -----
`timescale 1ns / 1ps
module tb_med_predicted_range_image_encoder_unit;
   import mpre_pkg::*;

   localparam int ROW_MAX = 4096;
   localparam int SETTLE_CYCLES = 17000;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int TARGET_PIXELS = 460;
   localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_red = 8'd0;
   logic [7:0]  req_green = 8'd0;
   logic [7:0]  req_blue = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [15:0] rsp_code_word;
   logic        rsp_last_of_run;
   logic        rsp_end_of_stream;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [15:0] csr_data = 16'd0;

   med_predicted_range_image_encoder_unit DUT (.*);

   always #10 clock = ~clock;

   // encoder mirror
   int unsigned img_width, img_height;
   int above_row[ROW_MAX][3];
   int west_px[3], nwest_px[3];
   int unsigned sym_count[3][256];
   int unsigned sym_total[3];
   int unsigned cum_freq[3][256];
   logic [63:0] enc_low, enc_range;
   int unsigned col_pos, row_pos;

   mpre_word_type expected_words[$];
   mpre_word_type pixel_words[$];

   int  idle_pct = 27;
   int  pixels_sent = 0;
   int  mismatches = 0;
   int  quiet_cycles = 0;

   function automatic void clear_encoder();
      for (int k = 0; k < ROW_MAX; k++) begin
         for (int c = 0; c < 3; c++) above_row[k][c] = 0;
      end
      for (int m = 0; m < 3; m++) begin
         west_px[m] = 0;
         nwest_px[m] = 0;
         for (int k = 0; k < 256; k++) begin
            sym_count[m][k] = 1;
            cum_freq[m][k] = k * 256;
         end
         sym_total[m] = 256;
      end
      enc_low = 64'd0;
      enc_range = MASK48;
      col_pos = 0;
      row_pos = 0;
   endfunction

   function automatic void emit_word(logic [63:0] w);
      mpre_word_type item;
      if (pixel_words.size() >= 12) return;
      item.code_word = w[15:0];
      item.last_of_run = 1'b0;
      item.end_of_stream = 1'b0;
      pixel_words.push_back(item);
   endfunction

   function automatic int median_edge(int n, int w, int nw);
      int lo, hi, p;
      lo = n < w ? n : w;
      hi = n < w ? w : n;
      p = n + w - nw;
      if (p < lo) p = lo;
      if (p > hi) p = hi;
      return p;
   endfunction

   function automatic int unsigned fold_residual(int diff);
      int unsigned r;
      r = diff & 255;
      return ((r << 1) ^ ((r & 128) ? 255 : 0)) & 255;
   endfunction

   function automatic void code_one(int m, int unsigned s);
      logic [63:0] lim, cdf, top, freq;
      for (int i = 0; i < 3 && enc_range < 64'h1_0000; i++) begin
         emit_word(enc_low >> 32);
         enc_low = (enc_low << 16) & MASK48;
         enc_range = ((enc_range << 16) | 64'hFFFF) & MASK48;
         lim = enc_low ^ MASK48;
         if (enc_range > lim) enc_range = lim;
      end
      cdf = 64'(cum_freq[m][s]);
      top = (s == 255) ? 64'h1_0000 : 64'(cum_freq[m][s + 1]);
      freq = top - cdf;
      enc_low = (enc_low + ((enc_range * cdf) >> 16)) & MASK48;
      enc_range = (((enc_range * freq) >> 16) - 64'd1) & MASK48;
   endfunction

   function automatic void rebuild_tables(int m);
      logic [63:0] total, c;
      int unsigned sum;
      total = sym_total[m] ? 64'(sym_total[m]) : 64'd1;
      c = 0;
      sum = 0;
      for (int k = 0; k < 256; k++) begin
         cum_freq[m][k] = 32'((c * 64'd65280) / total + k);
         c += sym_count[m][k];
      end
      for (int k = 0; k < 256; k++) begin
         sym_count[m][k] = (sym_count[m][k] + 1) >> 1;
         sum += sym_count[m][k];
      end
      sym_total[m] = sum;
   endfunction

   function automatic void encode_pixel(int r, int g, int b);
      int unsigned effw, effh, col;
      int nb[3], cur[3], pred[3], g0;
      int unsigned sym[3];
      effw = img_width == 0 ? 1 : (img_width > ROW_MAX ? ROW_MAX : img_width);
      effh = img_height == 0 ? 1 : img_height;
      col = col_pos >= ROW_MAX ? ROW_MAX - 1 : col_pos;
      pixel_words.delete();
      if (col == 0) begin
         for (int k = 0; k < 3; k++) begin
            west_px[k] = 0;
            nwest_px[k] = 0;
         end
      end
      for (int k = 0; k < 3; k++) begin
         nb[k] = above_row[col][k];
         pred[k] = median_edge(nb[k], west_px[k], nwest_px[k]);
      end
      g0 = g - 128;
      for (int k = 1; k < 3; k++) begin
         pred[k] += g0;
         if (pred[k] < -128) pred[k] = -128;
         if (pred[k] > 127) pred[k] = 127;
      end
      sym[0] = fold_residual(g0 - pred[0]);
      sym[1] = fold_residual((b - 128) - pred[1]);
      sym[2] = fold_residual((r - 128) - pred[2]);
      cur[0] = g0;
      cur[1] = b - g;
      cur[2] = r - g;
      for (int k = 0; k < 3; k++) begin
         code_one(k, sym[k]);
         sym_count[k][sym[k]]++;
         sym_total[k]++;
      end
      for (int k = 0; k < 3; k++) begin
         nwest_px[k] = nb[k];
         above_row[col][k] = cur[k];
         west_px[k] = cur[k];
      end
      if (col + 1 >= effw) begin
         for (int k = 0; k < 3; k++) rebuild_tables(k);
         col_pos = 0;
         if (row_pos + 1 >= effh) begin
            emit_word(enc_low >> 32);
            emit_word(enc_low >> 16);
            emit_word(enc_low);
            pixel_words[pixel_words.size() - 1].end_of_stream = 1'b1;
            clear_encoder();
         end else begin
            row_pos++;
         end
      end else begin
         col_pos = col + 1;
      end
      if (pixel_words.size() > 0) pixel_words[pixel_words.size() - 1].last_of_run = 1'b1;
      foreach (pixel_words[i]) expected_words.push_back(pixel_words[i]);
   endfunction

   task automatic write_csr(logic [1:0] idx, logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) img_width = value & 16'h1FFF;
      else img_height = value;
   endtask

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic stalled;
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      // full is sampled between edges so the accepting edge is known
      do begin
         @(negedge clock);
         stalled = req_full;
         @(posedge clock);
      end while (stalled);
      encode_pixel(r, g, b);
      pixels_sent++;
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      // row-end table rebuild can still be running after the last word
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_borders_and_extremes();
      write_csr(CSR_IMAGE_WIDTH, 16'd3);
      write_csr(CSR_IMAGE_HEIGHT, 16'd2);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd128, 8'd0);
      wait_idle();
   endtask

   task automatic test_size_clamping();
      // zero sizes count as one: each pixel is an image of its own
      write_csr(CSR_IMAGE_WIDTH, 16'd0);
      write_csr(CSR_IMAGE_HEIGHT, 16'd0);
      send_pixel(8'd17, 8'd200, 8'd3);
      send_pixel(8'd255, 8'd0, 8'd128);
      send_pixel(8'd1, 8'd254, 8'd127);
      wait_idle();
      // width beyond the row store, then shrunk below the column mid-image
      write_csr(CSR_IMAGE_WIDTH, 16'h1FFF);
      write_csr(CSR_IMAGE_HEIGHT, 16'd2);
      send_pixel(8'd10, 8'd20, 8'd30);
      send_pixel(8'd240, 8'd15, 8'd99);
      send_pixel(8'd85, 8'd170, 8'd85);
      send_pixel(8'd170, 8'd85, 8'd170);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 16'd2);
      send_pixel(8'd64, 8'd64, 8'd64);
      send_pixel(8'd0, 8'd127, 8'd255);
      send_pixel(8'd128, 8'd1, 8'd200);
      wait_idle();
   endtask

   task automatic test_tall_image_cut_short();
      write_csr(CSR_IMAGE_WIDTH, 16'd4096);
      write_csr(CSR_IMAGE_HEIGHT, 16'd65535);
      for (int i = 0; i < 6; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 16'd3);
      write_csr(CSR_IMAGE_HEIGHT, 16'd1);
      send_pixel(8'd33, 8'd44, 8'd55);
      wait_idle();
   endtask

   task automatic test_random_images();
      int w, h, mode, base_r, base_g, base_b;
      logic [7:0] r, g, b;
      while (pixels_sent < TARGET_PIXELS) begin
         w = ($urandom_range(9) == 0) ? 1 : $urandom_range(4, 40);
         h = $urandom_range(1, 3);
         mode = $urandom_range(3);
         idle_pct = ($urandom_range(3) == 0) ? 0 : 27;
         write_csr(CSR_IMAGE_WIDTH, 16'(w));
         write_csr(CSR_IMAGE_HEIGHT, 16'(h));
         base_r = $urandom_range(255);
         base_g = $urandom_range(255);
         base_b = $urandom_range(255);
         for (int i = 0; i < w * h; i++) begin
            if (mode == 0) begin
               r = 8'($urandom);
               g = 8'($urandom);
               b = 8'($urandom);
            end else if (mode == 3) begin
               r = 8'(base_r);
               g = 8'(base_g);
               b = 8'(base_b);
            end else begin
               // smooth gradient with small noise
               r = 8'(base_r + i + $urandom_range(3));
               g = 8'(base_g + 2 * i - $urandom_range(3));
               b = 8'(base_b - i + $urandom_range(5));
            end
            send_pixel(r, g, b);
         end
         wait_idle();
      end
      idle_pct = 27;
   endtask

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      mpre_word_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word %h last %b end %b", rsp_code_word,
                           rsp_last_of_run, rsp_end_of_stream);
            end else begin
               want = expected_words.pop_front();
               if (want.code_word !== rsp_code_word || want.last_of_run !== rsp_last_of_run
                   || want.end_of_stream !== rsp_end_of_stream) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("word mismatch: expected %h/%b/%b actual %h/%b/%b",
                              want.code_word, want.last_of_run, want.end_of_stream,
                              rsp_code_word, rsp_last_of_run, rsp_end_of_stream);
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_med_predicted_range_image_encoder_unit: FAIL");
            $finish;
         end
      end
   end

   initial begin
      img_width = 1;
      img_height = 1;
      clear_encoder();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_borders_and_extremes();
      test_size_clamping();
      test_tall_image_cut_short();
      test_random_images();
      wait_idle();
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("tb_med_predicted_range_image_encoder_unit: PASS");
      end else begin
         $display("tb_med_predicted_range_image_encoder_unit: FAIL");
      end
      $finish;
   end
endmodule
